// ===== hw/rtl/wsh_pkg.sv =====
// ---------------------------------------------------------------------------
// wsh_pkg
// Types and constants shared by the windowed sorted hit list blocks.
// ---------------------------------------------------------------------------
package wsh_pkg;

	localparam int MAX_HITS = 32;
	localparam int POS_W    = $clog2(MAX_HITS);
	localparam int CNT_W    = $clog2(MAX_HITS + 1);

	localparam logic        ACT_INSERT          = 1'b0;
	localparam logic        ACT_FLUSH           = 1'b1;
	localparam logic [1:0]  REG_LOW_LIMIT       = 2'd0;
	localparam logic [1:0]  REG_HIGH_LIMIT      = 2'd1;
	localparam logic [1:0]  REG_SORT_BY_CHANNEL = 2'd2;
	localparam logic [15:0] HIGH_LIMIT_RESET    = 16'd4096;

	typedef enum logic [2:0] {
		KIND_INSERTED = 3'd0,
		KIND_WINDOW   = 3'd1,
		KIND_FULL     = 3'd2,
		KIND_READ     = 3'd3,
		KIND_EMPTY    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OP_WINDOW = 2'd0,
		OP_INSERT = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [15:0] energy;
		logic [15:0] time_stamp;
		logic [7:0]  channel;
	} hit_t;

	typedef struct packed {
		op_t  op;
		hit_t hit;
	} qent_t;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] hit_total;
		hit_t             hit;
		logic             last;
	} res_t;

endpackage

// ===== hw/rtl/wsh_front.sv =====
// ---------------------------------------------------------------------------
// wsh_front
// Takes requests from the input stream, checks the energy window and
// queues each request with its class.
// ---------------------------------------------------------------------------
module wsh_front import wsh_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	input  logic [15:0] low_limit,
	input  logic [15:0] high_limit,
	input  logic        fifo_full,
	output logic        push,
	output qent_t       entry
);

	logic [15:0] energy;

	assign energy   = s_tdata[15:0];
	assign s_tready = !fifo_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		entry.hit.energy     = energy;
		entry.hit.time_stamp = s_tdata[31:16];
		entry.hit.channel    = s_tdata[39:32];
		if (s_tuser == ACT_FLUSH) begin
			entry.op = OP_FLUSH;
		end else if (energy <= low_limit || energy > high_limit) begin
			entry.op = OP_WINDOW;
		end else begin
			entry.op = OP_INSERT;
		end
	end

endmodule

// ===== hw/rtl/wsh_fifo.sv =====
// ---------------------------------------------------------------------------
// wsh_fifo
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module wsh_fifo import wsh_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wr_data,
	output logic  full,
	input  logic  pop,
	output qent_t rd_data,
	output logic  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	qent_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/wsh_back.sv =====
// ---------------------------------------------------------------------------
// wsh_back
// Holds the sorted hit cells, places inserts, reads out on flush and
// drives the result register.
// ---------------------------------------------------------------------------
module wsh_back import wsh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  sort_by_channel,
	input  logic  fifo_empty,
	input  qent_t head,
	output logic  pop,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLACE,
		ST_READ
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [POS_W-1:0]    rd_idx_q;
	logic [MAX_HITS-1:0] prec_q;
	hit_t                hold_q;
	hit_t                cell_q [MAX_HITS];
	logic                out_valid_q;
	res_t                out_q;

	logic                out_free;
	logic                place_fire;
	logic                read_fire;
	logic                res_load;
	logic [MAX_HITS-1:0] prec;
	logic [POS_W-1:0]    ins_pos;
	logic [CNT_W-1:0]    rd_next;

	function automatic res_t make_res(input kind_t k, input logic [POS_W-1:0] p,
			input logic [CNT_W-1:0] total, input hit_t h, input logic l);
		res_t r;
		r.kind      = k;
		r.position  = p;
		r.hit_total = total;
		r.hit       = h;
		r.last      = l;
		return r;
	endfunction

	assign out_free   = !out_valid_q || res_ready;
	assign pop        = (state_q == ST_IDLE) && !fifo_empty && out_free;
	assign place_fire = (state_q == ST_PLACE) && out_free;
	assign read_fire  = (state_q == ST_READ) && out_free;
	assign rd_next    = {1'b0, rd_idx_q} + 1'b1;
	assign res_valid  = out_valid_q;
	assign res        = out_q;

	always_comb begin
		res_load = place_fire || read_fire;
		if (pop) begin
			unique case (head.op)
				OP_WINDOW: res_load = 1'b1;
				OP_FLUSH:  res_load = count_q == '0;
				OP_INSERT: res_load = count_q == CNT_W'(MAX_HITS);
				default:   res_load = 1'b0;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_HITS; i++) begin
			prec[i] = (CNT_W'(i) < count_q) &&
				(sort_by_channel ? (head.hit.channel > cell_q[i].channel)
				                 : (head.hit.energy < cell_q[i].energy));
		end
	end

	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < MAX_HITS; i++) begin
			if (prec_q[i]) begin
				ins_pos = POS_W'(i + 1);
			end
		end
	end

	for (genvar g = 0; g < MAX_HITS; g++) begin : g_cell
		localparam int PREV = (g == 0) ? 0 : g - 1;
		localparam int NEXT = (g == MAX_HITS - 1) ? g : g + 1;
		always_ff @(posedge clk) begin
			if (place_fire) begin
				if (POS_W'(g) == ins_pos) begin
					cell_q[g] <= hold_q;
				end else if (POS_W'(g) > ins_pos) begin
					cell_q[g] <= cell_q[PREV];
				end
			end else if (read_fire) begin
				cell_q[g] <= cell_q[NEXT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prec_q <= prec;
			hold_q <= head.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_ready && !res_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.op)
							OP_WINDOW: begin
								out_valid_q <= 1'b1;
								out_q       <= make_res(KIND_WINDOW, '0, count_q, '0, 1'b1);
							end
							OP_FLUSH: begin
								if (count_q == '0) begin
									out_valid_q <= 1'b1;
									out_q       <= make_res(KIND_EMPTY, '0, '0, '0, 1'b1);
								end else begin
									rd_idx_q <= '0;
									state_q  <= ST_READ;
								end
							end
							OP_INSERT: begin
								if (count_q == CNT_W'(MAX_HITS)) begin
									out_valid_q <= 1'b1;
									out_q       <= make_res(KIND_FULL, '0, count_q, '0, 1'b1);
								end else begin
									state_q <= ST_PLACE;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PLACE: begin
					if (place_fire) begin
						out_valid_q <= 1'b1;
						out_q       <= make_res(KIND_INSERTED, ins_pos, count_q + 1'b1, '0,
							1'b1);
						count_q     <= count_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (read_fire) begin
						out_valid_q <= 1'b1;
						out_q       <= make_res(KIND_READ, rd_idx_q, '0, cell_q[0],
							rd_next == count_q);
						rd_idx_q    <= rd_next[POS_W-1:0];
						if (rd_next == count_q) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/windowed_sorted_hit_list_core.sv =====
// ---------------------------------------------------------------------------
// windowed_sorted_hit_list_core
// Sorted hit list of one event with an energy window and flush read-out.
// ---------------------------------------------------------------------------
// The input side takes one request per cycle while its two-entry queue has
// room; the list engine behind it works on one request at a time. An insert
// first compares the new key against all 32 stored hits as it is taken from
// the queue and registers the outcome, then places it and shifts the hits
// behind it. A request rejected for the energy window or a full list, and a
// flush of an empty list, are answered as soon as they are taken. A flush of
// n hits reads them out one by one from the head cell. Results leave through
// an output register; the engine starts or advances a request only when that
// register is empty or being taken, so a stalled result stream holds the engine.
module windowed_sorted_hit_list_core import wsh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // energy, time_stamp, channel
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // position, hit_total, out_energy, out_time, out_channel
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] low_limit_q;
	logic [15:0] high_limit_q;
	logic        sort_by_channel_q;

	logic  push;
	logic  pop;
	logic  fifo_full;
	logic  fifo_empty;
	qent_t wr_entry;
	qent_t head;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q       <= '0;
			high_limit_q      <= HIGH_LIMIT_RESET;
			sort_by_channel_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_LIMIT:       low_limit_q       <= cfg_wdata;
				REG_HIGH_LIMIT:      high_limit_q      <= cfg_wdata;
				REG_SORT_BY_CHANNEL: sort_by_channel_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	wsh_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.fifo_full  (fifo_full),
		.push       (push),
		.entry      (wr_entry)
	);

	wsh_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_entry),
		.full    (fifo_full),
		.pop     (pop),
		.rd_data (head),
		.empty   (fifo_empty)
	);

	wsh_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.sort_by_channel (sort_by_channel_q),
		.fifo_empty      (fifo_empty),
		.head            (head),
		.pop             (pop),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.res             (res)
	);

	assign m_tdata = {5'b0, res.hit.channel, res.hit.time_stamp, res.hit.energy,
		res.hit_total, res.position};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

	a_insert_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.kind == KIND_INSERTED |->
			res.hit_total != '0 && {1'b0, res.position} < res.hit_total)
		else $error("insert position outside the stored hits");

	a_read_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.kind == KIND_READ |-> res.hit_total == '0)
		else $error("read-out result with nonzero hit total");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.kind == KIND_INSERTED || res.kind == KIND_WINDOW ||
			res.kind == KIND_FULL || res.kind == KIND_EMPTY) |-> res.last)
		else $error("single result without last mark");

	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.kind == KIND_FULL |-> res.hit_total == CNT_W'(MAX_HITS))
		else $error("list full reported below capacity");

endmodule
